// ===== rtl/qmvd_pkg.sv =====
package qmvd_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int LANE_COUNT  = 4;
    localparam int QUANT_BLOCK = 32;

    localparam int IDX_W      = $clog2(MAX_COLUMNS);
    localparam int COL_W      = IDX_W + 1;
    localparam int LANE_W     = $clog2(LANE_COUNT);
    localparam int BANK_DEPTH = MAX_COLUMNS / LANE_COUNT;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int QB_W       = $clog2(QUANT_BLOCK);

    localparam int DATA_W     = 24;
    localparam int QUANT_W    = 8;
    localparam int FRAC_W     = 16;
    localparam int TERM_W     = 2 * DATA_W - FRAC_W;
    localparam int BLOCK_W    = 40;
    localparam int ROW_W      = 48;
    localparam int WIDE_W     = 64;
    localparam int SCALE_W    = 16;
    localparam int MANT_W     = 10;
    localparam int EXP_W      = 5;
    localparam int SCALED_W   = BLOCK_W + MANT_W + 2;
    localparam int ROWNUM_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int SCALE_SHIFT   = 25;
    localparam int SUBNORM_SHIFT = 24;

    localparam logic [EXP_W-1:0] EXP_SPECIAL = '1;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 2'd2;

    localparam logic FUNC_ACT    = 1'b0;
    localparam logic FUNC_WEIGHT = 1'b1;

    typedef struct packed {
        logic                     func;
        logic [IDX_W-1:0]         act_index;
        logic signed [DATA_W-1:0] act_value;
        logic signed [DATA_W-1:0] weight_lane_a;
        logic signed [DATA_W-1:0] weight_lane_b;
        logic signed [DATA_W-1:0] weight_lane_c;
        logic signed [DATA_W-1:0] weight_lane_d;
        logic [SCALE_W-1:0]       scale_bits;
    } t_in_item;

    typedef struct packed {
        logic signed [ROW_W-1:0] row_value;
        logic [ROWNUM_W-1:0]     row_number;
        logic                    last_row;
        logic                    saturated;
    } t_out_item;

    typedef struct packed {
        logic               clear;
        logic               acc_block;
        logic               acc_row;
        logic [LANE_W-1:0]  lane_sel;
        logic               close_mul;
        logic               close_shift;
        logic               close_apply;
        logic [SCALE_W-1:0] scale;
    } t_merge_ctl;

endpackage

// ===== rtl/qmvd_ram.sv =====
module qmvd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/qmvd_lane.sv =====
module qmvd_lane (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [qmvd_pkg::BANK_AW-1:0]        i_waddr,
    input  logic signed [qmvd_pkg::DATA_W-1:0]  i_wdata,
    input  logic [qmvd_pkg::BANK_AW-1:0]        i_raddr,
    input  logic signed [qmvd_pkg::DATA_W-1:0]  i_weight,
    input  logic                                i_q8,
    input  logic                                i_col_ok,
    input  logic                                i_prod_en,
    output logic signed [qmvd_pkg::TERM_W-1:0]  o_term
);

    logic [qmvd_pkg::DATA_W-1:0]          w_rdata;
    logic signed [qmvd_pkg::DATA_W-1:0]   w_act;
    logic signed [qmvd_pkg::DATA_W-1:0]   w_w;
    logic signed [2*qmvd_pkg::DATA_W-1:0] w_p;
    logic signed [qmvd_pkg::TERM_W-1:0]   n_term;
    logic signed [qmvd_pkg::TERM_W-1:0]   r_term;

    // activation bank for the columns this lane sees
    qmvd_ram #(
        .WIDTH(qmvd_pkg::DATA_W),
        .DEPTH(qmvd_pkg::BANK_DEPTH)
    ) u_bank (
        .i_clk  (i_clk),
        .i_we   (i_we),
        .i_waddr(i_waddr),
        .i_wdata(i_wdata),
        .i_raddr(i_raddr),
        .o_rdata(w_rdata)
    );

    assign w_act = $signed(w_rdata);
    assign w_w   = i_q8 ? {{(qmvd_pkg::DATA_W-qmvd_pkg::QUANT_W){i_weight[qmvd_pkg::QUANT_W-1]}},
                           i_weight[qmvd_pkg::QUANT_W-1:0]}
                        : i_weight;
    assign w_p   = w_w * w_act;

    always_comb begin
        if (!i_col_ok) begin
            n_term = '0;
        end else if (i_q8) begin
            n_term = w_p[qmvd_pkg::TERM_W-1:0];
        end else begin
            n_term = w_p[2*qmvd_pkg::DATA_W-1:qmvd_pkg::FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_prod_en) begin
            r_term <= n_term;
        end
    end

    assign o_term = r_term;

endmodule

// ===== rtl/qmvd_merge.sv =====
module qmvd_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  qmvd_pkg::t_merge_ctl               i_ctl,
    input  logic signed [qmvd_pkg::TERM_W-1:0] i_terms [qmvd_pkg::LANE_COUNT],
    output logic signed [qmvd_pkg::ROW_W-1:0]  o_row_sum,
    output logic                               o_sat
);

    localparam int WW = qmvd_pkg::WIDE_W;
    localparam int RW = qmvd_pkg::ROW_W;
    localparam int BW = qmvd_pkg::BLOCK_W;
    localparam int TW = qmvd_pkg::TERM_W;
    localparam int EW = qmvd_pkg::EXP_W;
    localparam int MW = qmvd_pkg::MANT_W;
    localparam int SW = qmvd_pkg::SCALED_W;

    localparam logic signed [WW-1:0] SUM_MAX = {{(WW-RW+1){1'b0}}, {(RW-1){1'b1}}};
    localparam logic signed [WW-1:0] SUM_MIN = {{(WW-RW+1){1'b1}}, {(RW-1){1'b0}}};
    localparam logic signed [RW-1:0] ROW_MAX = {1'b0, {(RW-1){1'b1}}};
    localparam logic signed [RW-1:0] ROW_MIN = {1'b1, {(RW-1){1'b0}}};

    logic signed [BW-1:0] r_block;
    logic signed [RW-1:0] r_row;
    logic                 r_sat;
    logic signed [SW-1:0] r_scaled;
    logic signed [WW-1:0] r_wide;

    logic signed [BW-1:0] w_tree;
    logic signed [TW-1:0] w_term;
    logic signed [WW-1:0] w_add;
    logic signed [WW-1:0] w_sum;
    logic                 w_hi;
    logic                 w_lo;
    logic signed [RW-1:0] w_clamp;
    logic [EW-1:0]        w_exp;
    logic [MW-1:0]        w_man;
    logic                 w_neg;
    logic signed [MW+1:0] w_mant;
    logic signed [SW-1:0] w_prod;
    logic signed [WW-1:0] w_sgn;
    logic signed [WW-1:0] w_shifted;
    logic                 w_pos;

    // four lane terms into the block sum
    always_comb begin
        w_tree = '0;
        for (int k = 0; k < qmvd_pkg::LANE_COUNT; k++) begin
            w_tree = w_tree + {{(BW-TW){i_terms[k][TW-1]}}, i_terms[k]};
        end
    end

    assign w_term  = i_terms[i_ctl.lane_sel];
    assign w_add   = i_ctl.close_apply ? r_wide : {{(WW-TW){w_term[TW-1]}}, w_term};
    assign w_sum   = {{(WW-RW){r_row[RW-1]}}, r_row} + w_add;
    assign w_hi    = w_sum > SUM_MAX;
    assign w_lo    = w_sum < SUM_MIN;
    assign w_clamp = w_hi ? ROW_MAX : (w_lo ? ROW_MIN : w_sum[RW-1:0]);

    // fp16 scale fields
    assign w_exp  = i_ctl.scale[MW+EW-1:MW];
    assign w_man  = i_ctl.scale[MW-1:0];
    assign w_neg  = i_ctl.scale[qmvd_pkg::SCALE_W-1];
    assign w_mant = (w_exp == '0) ? {2'b00, w_man} : {2'b01, w_man};
    assign w_prod = r_block * w_mant;
    assign w_pos  = (!w_neg) == (!r_block[BW-1]);

    assign w_sgn = w_neg ? -{{(WW-SW){r_scaled[SW-1]}}, r_scaled}
                         :  {{(WW-SW){r_scaled[SW-1]}}, r_scaled};

    always_comb begin
        if (w_exp == '0) begin
            w_shifted = w_sgn >>> EW'(qmvd_pkg::SUBNORM_SHIFT);
        end else if (w_exp >= EW'(qmvd_pkg::SCALE_SHIFT)) begin
            w_shifted = w_sgn <<< (w_exp - EW'(qmvd_pkg::SCALE_SHIFT));
        end else begin
            w_shifted = w_sgn >>> (EW'(qmvd_pkg::SCALE_SHIFT) - w_exp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block <= '0;
            r_row   <= '0;
            r_sat   <= 1'b0;
        end else if (i_ctl.clear) begin
            r_block <= '0;
            r_row   <= '0;
            r_sat   <= 1'b0;
        end else begin
            if (i_ctl.acc_block) begin
                r_block <= r_block + w_tree;
            end
            if (i_ctl.acc_row || i_ctl.close_apply) begin
                r_row <= w_clamp;
                r_sat <= r_sat | w_hi | w_lo;
            end
            if (i_ctl.close_mul && w_exp == qmvd_pkg::EXP_SPECIAL) begin
                r_row   <= w_pos ? ROW_MAX : ROW_MIN;
                r_sat   <= 1'b1;
                r_block <= '0;
            end
            if (i_ctl.close_shift) begin
                r_block <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.close_mul) begin
            r_scaled <= w_prod;
        end
        if (i_ctl.close_shift) begin
            r_wide <= w_shifted;
        end
    end

    assign o_row_sum = r_row;
    assign o_sat     = r_sat;

endmodule

// ===== rtl/quantized_matrix_vector_dot.sv =====
// Matrix-vector product engine. func 0 items store one activation. func 1 items carry four
// weights: plain fixed-point items pass a bank read, a lane multiply, then a saturating row
// add of one lane per cycle; Q8_0 items pass the read, the multiply and one block add, plus
// the fp16 scale multiply, shift and row add on the last item of a 32-column block, or only
// the multiply when that scale is infinite or NaN and the row sum is forced to its limit. An
// item that ends a row then hands its result to the output register in an emit state that
// waits while an earlier result is still held. Activations sit in four banks, one per lane,
// interleaved by column. A write to a configuration register drops the matrix in progress.
module quantized_matrix_vector_dot (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  qmvd_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output qmvd_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [qmvd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [qmvd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CW = qmvd_pkg::COL_W;
    localparam int LW = qmvd_pkg::LANE_W;
    localparam int NW = qmvd_pkg::ROWNUM_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_PROD  = 8'b0000_0100,
        S_ACC   = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_SHIFT = 8'b0010_0000,
        S_APPLY = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state                              r_state;
    t_state                              n_state;
    logic                                r_fmt;
    logic [CW-1:0]                       r_len_cfg;
    logic [NW-1:0]                       r_cnt_cfg;
    logic [CW-1:0]                       r_col;
    logic [NW-1:0]                       r_rowpos;
    logic [LW-1:0]                       r_lane;
    logic                                r_row_end;
    logic signed [qmvd_pkg::DATA_W-1:0]  r_w [qmvd_pkg::LANE_COUNT];
    logic [qmvd_pkg::SCALE_W-1:0]        r_scale;
    logic                                r_out_valid;
    qmvd_pkg::t_out_item                 r_out;

    logic signed [qmvd_pkg::DATA_W-1:0]  w_in_w [qmvd_pkg::LANE_COUNT];
    logic signed [qmvd_pkg::TERM_W-1:0]  w_terms [qmvd_pkg::LANE_COUNT];
    logic                                w_in_acc;
    logic                                w_act_wr;
    logic                                w_cfg_hit;
    logic [CW-1:0]                       w_len_clip;
    logic [CW-1:0]                       w_len_q;
    logic [CW-1:0]                       w_len;
    logic [CW-1:0]                       w_col_next;
    logic                                w_row_end;
    logic                                w_block_end;
    logic                                w_acc_last;
    logic                                w_special;
    logic [NW:0]                         w_cnt;
    logic [NW:0]                         w_pos_next;
    logic                                w_last;
    logic                                w_out_load;
    logic signed [qmvd_pkg::ROW_W-1:0]   w_row_sum;
    logic                                w_sat;
    qmvd_pkg::t_merge_ctl                w_ctl;

    assign w_in_w[0] = i_in_data.weight_lane_a;
    assign w_in_w[1] = i_in_data.weight_lane_b;
    assign w_in_w[2] = i_in_data.weight_lane_c;
    assign w_in_w[3] = i_in_data.weight_lane_d;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_act_wr   = w_in_acc && (i_in_data.func == qmvd_pkg::FUNC_ACT);

    // effective row length
    always_comb begin
        if (r_len_cfg == '0) begin
            w_len_clip = CW'(1);
        end else if (r_len_cfg > CW'(qmvd_pkg::MAX_COLUMNS)) begin
            w_len_clip = CW'(qmvd_pkg::MAX_COLUMNS);
        end else begin
            w_len_clip = r_len_cfg;
        end
    end

    assign w_len_q = {w_len_clip[CW-1:qmvd_pkg::QB_W], {qmvd_pkg::QB_W{1'b0}}};
    assign w_len   = !r_fmt ? w_len_clip
                            : ((w_len_q == '0) ? CW'(qmvd_pkg::QUANT_BLOCK) : w_len_q);

    assign w_col_next  = r_col + CW'(qmvd_pkg::LANE_COUNT);
    assign w_row_end   = w_col_next >= w_len;
    assign w_block_end = r_fmt && (w_row_end || w_col_next[qmvd_pkg::QB_W-1:0] == '0);
    assign w_acc_last  = r_fmt || (r_lane == LW'(qmvd_pkg::LANE_COUNT - 1));
    assign w_special   = r_scale[qmvd_pkg::MANT_W+qmvd_pkg::EXP_W-1:qmvd_pkg::MANT_W]
                         == qmvd_pkg::EXP_SPECIAL;

    assign w_cnt      = (r_cnt_cfg == '0) ? {1'b1, {NW{1'b0}}} : {1'b0, r_cnt_cfg};
    assign w_pos_next = {1'b0, r_rowpos} + (NW+1)'(1);
    assign w_last     = w_pos_next >= w_cnt;
    assign w_out_load = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        unique case (i_cfg_index)
            qmvd_pkg::REG_WEIGHT_FORMAT,
            qmvd_pkg::REG_ROW_LENGTH,
            qmvd_pkg::REG_ROW_COUNT: w_cfg_hit = i_cfg_we;
            default:                 w_cfg_hit = 1'b0;
        endcase
    end

    // lanes
    for (genvar k = 0; k < qmvd_pkg::LANE_COUNT; k++) begin : g_lane
        logic w_col_ok;

        assign w_col_ok = ({1'b0, r_col} + (CW+1)'(k)) < {1'b0, w_len};

        qmvd_lane u_lane (
            .i_clk    (i_clk),
            .i_we     (w_act_wr && i_in_data.act_index[LW-1:0] == LW'(k)),
            .i_waddr  (i_in_data.act_index[qmvd_pkg::IDX_W-1:LW]),
            .i_wdata  (i_in_data.act_value),
            .i_raddr  (r_col[qmvd_pkg::IDX_W-1:LW]),
            .i_weight (r_w[k]),
            .i_q8     (r_fmt),
            .i_col_ok (w_col_ok),
            .i_prod_en(r_state == S_PROD),
            .o_term   (w_terms[k])
        );
    end

    assign w_ctl.clear       = w_cfg_hit || w_out_load;
    assign w_ctl.acc_block   = (r_state == S_ACC) && r_fmt;
    assign w_ctl.acc_row     = (r_state == S_ACC) && !r_fmt;
    assign w_ctl.lane_sel    = r_lane;
    assign w_ctl.close_mul   = (r_state == S_MUL);
    assign w_ctl.close_shift = (r_state == S_SHIFT);
    assign w_ctl.close_apply = (r_state == S_APPLY);
    assign w_ctl.scale       = r_scale;

    qmvd_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_terms  (w_terms),
        .o_row_sum(w_row_sum),
        .o_sat    (w_sat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_in_data.func == qmvd_pkg::FUNC_WEIGHT) begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = S_PROD;
            S_PROD:  n_state = S_ACC;
            S_ACC: begin
                if (w_acc_last) begin
                    if (w_block_end) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = w_row_end ? S_EMIT : S_IDLE;
                    end
                end
            end
            S_MUL: begin
                if (w_special) begin
                    n_state = r_row_end ? S_EMIT : S_IDLE;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: n_state = S_APPLY;
            S_APPLY: n_state = r_row_end ? S_EMIT : S_IDLE;
            S_EMIT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fmt       <= 1'b1;
            r_len_cfg   <= CW'(qmvd_pkg::MAX_COLUMNS);
            r_cnt_cfg   <= NW'(1);
            r_col       <= '0;
            r_rowpos    <= '0;
            r_lane      <= '0;
            r_row_end   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    qmvd_pkg::REG_WEIGHT_FORMAT: r_fmt     <= i_cfg_data[0];
                    qmvd_pkg::REG_ROW_LENGTH:    r_len_cfg <= i_cfg_data[CW-1:0];
                    qmvd_pkg::REG_ROW_COUNT:     r_cnt_cfg <= i_cfg_data[NW-1:0];
                    default: ;
                endcase
            end
            if (w_cfg_hit) begin
                r_col    <= '0;
                r_rowpos <= '0;
            end
            if (r_state == S_ACC) begin
                if (w_acc_last) begin
                    r_lane    <= '0;
                    r_col     <= w_col_next;
                    r_row_end <= w_row_end;
                end else begin
                    r_lane <= r_lane + LW'(1);
                end
            end
            if (w_out_load) begin
                r_col       <= '0;
                r_rowpos    <= w_last ? '0 : w_pos_next[NW-1:0];
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in_data.func == qmvd_pkg::FUNC_WEIGHT) begin
            r_w     <= w_in_w;
            r_scale <= i_in_data.scale_bits;
        end
        if (w_out_load) begin
            r_out.row_value  <= w_row_sum;
            r_out.row_number <= r_rowpos;
            r_out.last_row   <= w_last;
            r_out.saturated  <= w_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== dv/tb_quantized_matrix_vector_dot.sv =====
module tb_quantized_matrix_vector_dot;
    import qmvd_pkg::*;

    localparam int     RANDOM_ITEMS  = 900;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     END_CYCLES    = 24;
    localparam int     QUIET_LIMIT   = 5000;
    localparam int     HOLD_AFTER    = 20;
    localparam int     HOLD_CYCLES   = 500;
    localparam int     HOLD_QUEUE    = 64;
    localparam longint ROW_HI        = (64'sd1 <<< (ROW_W - 1)) - 64'sd1;
    localparam longint ROW_LO        = -ROW_HI - 64'sd1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_WEIGHT_FORMAT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    t_in_item  stim_q [$];
    t_out_item pending_rows [$];

    // predicted block state
    logic signed [DATA_W-1:0] act_shadow [MAX_COLUMNS];
    bit                       fmt_q8 = 1'b1;
    logic [12:0]              len_reg = 13'd4096;
    logic [ROWNUM_W-1:0]      count_reg = 16'd1;
    int unsigned              col_pos = 0;
    longint                   block_acc = 0;
    longint                   row_acc = 0;
    int unsigned              row_idx = 0;
    bit                       sat_flag = 1'b0;

    bit          act_loaded [MAX_COLUMNS];
    int unsigned queued_items = 0;
    int          send_gap_pct = 26;
    int          recv_gap_pct = 63;
    int          error_count = 0;
    int          rows_seen = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          quiet_cycles = 0;

    quantized_matrix_vector_dot u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned effective_len(input bit q8, input logic [12:0] raw);
        int unsigned n;
        n = raw;
        if (n == 0) n = 1;
        if (n > MAX_COLUMNS) n = MAX_COLUMNS;
        if (q8) begin
            n = (n / QUANT_BLOCK) * QUANT_BLOCK;
            if (n == 0) n = QUANT_BLOCK;
        end
        return n;
    endfunction

    function automatic void add_to_row(input longint v);
        longint s;
        s = row_acc + v;
        if (s > ROW_HI) begin
            s = ROW_HI;
            sat_flag = 1'b1;
        end
        if (s < ROW_LO) begin
            s = ROW_LO;
            sat_flag = 1'b1;
        end
        row_acc = s;
    endfunction

    // fp16 scale times block dot product, floored at 16 fraction bits
    function automatic void scale_block(input logic [SCALE_W-1:0] bits);
        logic [EXP_W-1:0]  ex;
        logic [MANT_W-1:0] man;
        longint            p;
        int                sh;
        ex  = bits[14:10];
        man = bits[MANT_W-1:0];
        if (ex == EXP_SPECIAL) begin
            row_acc  = (bits[15] == (block_acc < 0)) ? ROW_HI : ROW_LO;
            sat_flag = 1'b1;
        end else begin
            if (ex == 0) begin
                p  = block_acc * longint'(man);
                sh = -SUBNORM_SHIFT;
            end else begin
                p  = block_acc * longint'({1'b1, man});
                sh = int'(ex) - SCALE_SHIFT;
            end
            if (bits[15]) p = -p;
            if (sh >= 0) p = p <<< sh;
            else p = p >>> (-sh);
            add_to_row(p);
        end
        block_acc = 0;
    endfunction

    function automatic void clear_progress();
        col_pos   = 0;
        block_acc = 0;
        row_acc   = 0;
        row_idx   = 0;
        sat_flag  = 1'b0;
    endfunction

    // advance the dot product by one accepted transfer
    function automatic void accumulate_item(input t_in_item it);
        int unsigned              n;
        int unsigned              total;
        bit                       ends;
        bit                       fin;
        longint                   x;
        logic signed [DATA_W-1:0] lane [LANE_COUNT];
        logic signed [7:0]        q;
        t_out_item                res;
        if (it.func == FUNC_ACT) begin
            act_shadow[it.act_index] = it.act_value;
            return;
        end
        n = effective_len(fmt_q8, len_reg);
        lane[0] = it.weight_lane_a;
        lane[1] = it.weight_lane_b;
        lane[2] = it.weight_lane_c;
        lane[3] = it.weight_lane_d;
        for (int k = 0; k < LANE_COUNT; k++) begin
            if (col_pos + k < n) begin
                x = act_shadow[col_pos + k];
                if (fmt_q8) begin
                    q = lane[k][QUANT_W-1:0];
                    block_acc += longint'(q) * x;
                end else begin
                    add_to_row((longint'(lane[k]) * x) >>> FRAC_W);
                end
            end
        end
        col_pos += LANE_COUNT;
        ends = col_pos >= n;
        if (fmt_q8 && (ends || col_pos % QUANT_BLOCK == 0)) scale_block(it.scale_bits);
        if (ends) begin
            total = (count_reg == 0) ? 65536 : count_reg;
            fin = row_idx + 1 >= total;
            res.row_value  = row_acc[ROW_W-1:0];
            res.row_number = row_idx[ROWNUM_W-1:0];
            res.last_row   = fin;
            res.saturated  = sat_flag;
            pending_rows.push_back(res);
            col_pos   = 0;
            block_acc = 0;
            row_acc   = 0;
            sat_flag  = 1'b0;
            row_idx   = fin ? 0 : ((row_idx + 1) & 16'hFFFF);
        end
    endfunction

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) accumulate_item(in_data);
            if (!in_valid || !in_stall) begin
                if (stim_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    in_data  <= stim_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic signed [63:0] want_v,
                               input logic signed [63:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            error_count++;
        end
    endtask

    // output side
    always @(posedge i_clk) begin : rx_side
        t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                rows_seen++;
                if (pending_rows.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, got %h",
                             $time, out_data);
                    error_count++;
                end else begin
                    want = pending_rows.pop_front();
                    check_field("row_value", $signed(want.row_value),
                                $signed(out_data.row_value));
                    check_field("row_number", want.row_number, out_data.row_number);
                    check_field("last_row", want.last_row, out_data.last_row);
                    check_field("saturated", want.saturated, out_data.saturated);
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end else if (!hold_done && rows_seen >= HOLD_AFTER
                         && stim_q.size() >= HOLD_QUEUE) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_gap_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_quantized_matrix_vector_dot failed");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] rand_lane(input bit q8);
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0: r[DATA_W-1:0] = 24'h7FFFFF;
            1: r[DATA_W-1:0] = 24'h800000;
            2: r[DATA_W-1:0] = '0;
            3: if (q8) r[7:0] = 8'h7F;
            4: if (q8) r[7:0] = 8'h80;
            default: ;
        endcase
        return r[DATA_W-1:0];
    endfunction

    function automatic logic [SCALE_W-1:0] rand_scale();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0: r[14:10] = EXP_SPECIAL;
            1: r[14:10] = '0;
            2, 3: r[14:10] = 5'($urandom_range(27, 30));
            default: ;
        endcase
        return r[SCALE_W-1:0];
    endfunction

    function automatic t_in_item junk_item();
        logic [159:0] r;
        t_in_item     it;
        r  = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it = r[$bits(t_in_item)-1:0];
        return it;
    endfunction

    task automatic push_act(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        t_in_item it;
        it = junk_item();
        it.func      = FUNC_ACT;
        it.act_index = idx;
        it.act_value = val;
        act_loaded[idx] = 1'b1;
        stim_q.push_back(it);
        queued_items++;
    endtask

    task automatic push_weights(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                                input logic [DATA_W-1:0] c, input logic [DATA_W-1:0] d,
                                input logic [SCALE_W-1:0] scale);
        t_in_item it;
        it = junk_item();
        it.func          = FUNC_WEIGHT;
        it.weight_lane_a = a;
        it.weight_lane_b = b;
        it.weight_lane_c = c;
        it.weight_lane_d = d;
        it.scale_bits    = scale;
        stim_q.push_back(it);
        queued_items++;
    endtask

    task automatic fill_acts(input int unsigned n);
        for (int i = 0; i < n; i++)
            if (!act_loaded[i]) push_act(IDX_W'(i), rand_lane(1'b0));
    endtask

    task automatic push_row(input bit q8, input int unsigned groups);
        for (int g = 0; g < groups; g++) begin
            if ($urandom_range(11) == 0) push_act(IDX_W'($urandom), rand_lane(1'b0));
            push_weights(rand_lane(q8), rand_lane(q8), rand_lane(q8), rand_lane(q8),
                         rand_scale());
        end
    endtask

    task automatic program_regs(input bit q8, input int unsigned len, input int unsigned cnt);
        while (stim_q.size() != 0 || in_valid || pending_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WEIGHT_FORMAT;
        cfg_data  <= CFG_DATA_W'(q8);
        @(posedge i_clk);
        cfg_index <= REG_ROW_LENGTH;
        cfg_data  <= CFG_DATA_W'(len);
        @(posedge i_clk);
        cfg_index <= REG_ROW_COUNT;
        cfg_data  <= CFG_DATA_W'(cnt);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        fmt_q8    = q8;
        len_reg   = len[12:0];
        count_reg = cnt[ROWNUM_W-1:0];
        clear_progress();
    endtask

    initial begin : stimulus
        int unsigned start;
        int unsigned stage;
        int unsigned len;
        int unsigned cnt;
        int unsigned groups;
        int unsigned rows;
        bit          q8;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // plain rows of five columns: tail lanes and the last row flag
        program_regs(1'b0, 5, 2);
        push_act(0, 24'h7FFFFF);
        push_act(1, 24'h800000);
        push_act(2, 24'h000000);
        push_act(3, 24'hFFFFFF);
        push_act(4, 24'h7FFFFF);
        fill_acts(QUANT_BLOCK);
        push_weights(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, '0);
        push_weights(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, '0);
        push_row(1'b0, 2);
        // half a row, dropped by the register writes below
        push_row(1'b0, 1);

        // q8 blocks: largest finite scale, then negative infinity on a zero block
        program_regs(1'b1, 32, 0);
        for (int g = 0; g < 8; g++)
            push_weights(24'h00007F, 24'h00007F, 24'h00007F, 24'h00007F,
                         (g == 7) ? 16'h7BFF : rand_scale());
        for (int g = 0; g < 8; g++)
            push_weights(24'hABCD00, 24'h123400, 24'hFFFF00, 24'h800000,
                         (g == 7) ? 16'hFC00 : rand_scale());

        // zero row length acts as one column
        program_regs(1'b0, 0, 65535);
        push_row(1'b0, 1);

        start = queued_items;
        while (queued_items - start < RANDOM_ITEMS) begin
            q8 = $urandom_range(1);
            case ($urandom_range(7))
                0: len = 0;
                1: len = 1;
                6: len = 64;
                7: len = $urandom_range(33, 100);
                default: len = $urandom_range(2, 40);
            endcase
            case ($urandom_range(5))
                0: cnt = 0;
                1: cnt = 65535;
                default: cnt = $urandom_range(1, 4);
            endcase
            program_regs(q8, len, cnt);
            stage = (queued_items - start) * 3 / RANDOM_ITEMS;
            send_gap_pct = (stage == 0) ? 26 : (stage == 1) ? 63 : 0;
            recv_gap_pct = (stage == 0) ? 63 : (stage == 1) ? 26 : 0;
            groups = (effective_len(q8, len[12:0]) + LANE_COUNT - 1) / LANE_COUNT;
            fill_acts(groups * LANE_COUNT);
            rows = $urandom_range(1, 6);
            for (int r = 0; r < rows; r++) push_row(q8, groups);
            if ($urandom_range(3) == 0 && groups > 1) push_row(q8, $urandom_range(1, groups - 1));
        end

        while (stim_q.size() != 0 || in_valid || pending_rows.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_quantized_matrix_vector_dot passed");
        end else begin
            $display("tb_quantized_matrix_vector_dot failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/qmvd_pkg.sv
rtl/qmvd_ram.sv
rtl/qmvd_lane.sv
rtl/qmvd_merge.sv
rtl/quantized_matrix_vector_dot.sv
dv/tb_quantized_matrix_vector_dot.sv
